[src/pscr_pkg.sv]
// Shared types and constants for the positioner serial command responder.
`default_nettype none
package pscr_pkg;

  localparam logic [7:0] CMD_STATUS   = 8'h8D;
  localparam logic [7:0] CMD_POS_X    = 8'h8E;
  localparam logic [7:0] CMD_POS_Y    = 8'h8F;
  localparam logic [7:0] CMD_POS_Z    = 8'h90;
  localparam logic [7:0] CMD_TGT_X    = 8'hCE;
  localparam logic [7:0] CMD_TGT_Y    = 8'hCF;
  localparam logic [7:0] CMD_TGT_Z    = 8'hD0;
  localparam logic [7:0] CMD_MOVE     = 8'h10;

  localparam logic [7:0] SUB_STATUS   = 8'd0;
  localparam logic [7:0] SUB_JOY_X    = 8'd1;
  localparam logic [7:0] SUB_JOY_Y    = 8'd2;
  localparam logic [7:0] SUB_REVISION = 8'd3;
  localparam logic [7:0] SUB_CHECKSUM = 8'd4;
  localparam logic [7:0] SUB_NEEDLE   = 8'd5;
  localparam logic [7:0] SUB_PEEK     = 8'd6;

  localparam logic [7:0] SUB_AXIS_POS = 8'd0;
  localparam logic [7:0] SUB_AXIS_TGT = 8'd1;

  localparam logic [7:0] SUB_MOVE_XYZ  = 8'd0;
  localparam logic [7:0] SUB_MOVE_STEP = 8'd2;
  localparam logic [7:0] SUB_MOVE_HOME = 8'd3;

  localparam logic [7:0] ARG_CLEAR    = 8'd1;

  localparam logic [1:0] KIND_XYZ     = 2'd0;
  localparam logic [1:0] KIND_HOME    = 2'd1;
  localparam logic [1:0] KIND_STEP    = 2'd2;

  localparam logic [7:0] STAT_MOVING    = 8'h01;
  localparam logic [7:0] STAT_READY     = 8'h42;
  localparam logic [7:0] STAT_HOME      = 8'h44;
  localparam logic [7:0] STAT_HIGH_INIT = 8'h80;
  localparam logic [7:0] CLR_MASK_LOW   = 8'h3F;
  localparam logic [7:0] CLR_MASK_HIGH  = 8'h7F;
  localparam logic [7:0] KEEP_MASK_HIGH = 8'hA0;

  localparam logic [2:0] REG_REVISION  = 3'd0;
  localparam logic [2:0] REG_CKSUM_LO  = 3'd1;
  localparam logic [2:0] REG_CKSUM_HI  = 3'd2;
  localparam logic [2:0] REG_HOLD      = 3'd3;
  localparam logic [2:0] REG_Z_STEP    = 3'd4;
  localparam logic [2:0] REG_Z_LIMIT   = 3'd5;

  typedef struct packed {
    logic [7:0]       status_low;
    logic [7:0]       status_high;
    logic [2:0][15:0] pos;
    logic [2:0][15:0] tgt;
    logic [1:0][15:0] joy;
    logic [4:0]       buttons;
    logic [3:0]       hold;
    logic             pending;
    logic [1:0]       kind;
    logic             armed;
  } state_t;

  localparam state_t STATE_RESET = '{
    status_low:  8'd0,
    status_high: 8'd0,
    pos:         '0,
    tgt:         '0,
    joy:         '0,
    buttons:     5'd0,
    hold:        4'd0,
    pending:     1'b0,
    kind:        KIND_XYZ,
    armed:       1'b1
  };

  typedef struct packed {
    logic [7:0]  revision_code;
    logic [7:0]  checksum_low;
    logic [7:0]  checksum_high;
    logic [3:0]  button_hold_ticks;
    logic [7:0]  z_step;
    logic [15:0] z_limit;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  cmd_code;
    logic [7:0]  cmd_sub;
    logic [7:0]  cmd_arg;
    logic        link_up;
    logic        unlock_pressed;
    logic [15:0] joystick_x;
    logic [15:0] joystick_y;
    logic [15:0] needle_value;
    logic        buttons_write;
    logic [4:0]  console_buttons;
  } item_t;

  typedef struct packed {
    logic [7:0] code;
    logic [7:0] low;
    logic [7:0] high;
    logic [7:0] check;
  } reply_t;

endpackage
`default_nettype wire

[src/pscr_step.sv]
// Next-state and reply logic for one frame or tick of the responder.
`default_nettype none
module pscr_step (
  input  wire pscr_pkg::state_t st,
  input  wire pscr_pkg::cfg_t   cfg,
  input  wire pscr_pkg::item_t  item,
  output pscr_pkg::state_t      st_nxt,
  output pscr_pkg::reply_t      rep
);

  always_comb begin
    pscr_pkg::state_t s;
    logic [7:0]  r_code;
    logic [7:0]  r_low;
    logic [7:0]  r_high;
    logic [16:0] zsum;
    s      = st;
    r_code = 8'd0;
    r_low  = 8'd0;
    r_high = 8'd0;
    zsum   = {1'b0, st.tgt[2]} + {9'd0, cfg.z_step};

    if (item.buttons_write) begin
      s.buttons = item.console_buttons;
      s.hold    = cfg.button_hold_ticks;
    end

    if (item.op) begin
      if (!item.link_up) begin
        s.armed = 1'b1;
      end else begin
        if (s.armed) begin
          s.status_low  = pscr_pkg::STAT_READY;
          s.status_high = pscr_pkg::STAT_HIGH_INIT;
          s.pos         = '0;
          s.buttons     = '0;
          s.hold        = '0;
          s.pending     = 1'b0;
          s.armed       = 1'b0;
        end
        if (s.hold == 4'd0) begin
          s.buttons = '0;
        end else begin
          s.hold = s.hold - 4'd1;
        end
        s.status_high = (s.status_high & pscr_pkg::KEEP_MASK_HIGH) | {3'd0, s.buttons};
        if (s.status_high[3]) begin
          s.joy[0] = item.joystick_x;
          s.joy[1] = item.joystick_y;
        end
        if (item.unlock_pressed) begin
          s.status_high[6] = 1'b1;
        end
        if (s.pending) begin
          case (s.kind)
            pscr_pkg::KIND_HOME: begin
              s.tgt = '0;
            end
            pscr_pkg::KIND_STEP: begin
              if (s.tgt[2] > cfg.z_limit) begin
                s.tgt[2] = cfg.z_limit;
              end else if (zsum[16]) begin
                s.tgt[2] = 16'hFFFF;
              end else begin
                s.tgt[2] = zsum[15:0];
              end
            end
            default: begin
            end
          endcase
          s.pos = s.tgt;
          if (s.tgt == '0) begin
            s.status_low = pscr_pkg::STAT_HOME;
          end else begin
            s.status_low = pscr_pkg::STAT_READY;
          end
          s.pending = 1'b0;
        end
      end
    end else if (!st.pending && item.link_up) begin
      case (item.cmd_code)
        pscr_pkg::CMD_STATUS: begin
          case (item.cmd_sub)
            pscr_pkg::SUB_STATUS: begin
              r_code = item.cmd_code;
              r_low  = st.status_low;
              r_high = st.status_high;
              if (item.cmd_arg == pscr_pkg::ARG_CLEAR) begin
                s.status_low  = st.status_low & pscr_pkg::CLR_MASK_LOW;
                s.status_high = st.status_high & pscr_pkg::CLR_MASK_HIGH;
              end
            end
            pscr_pkg::SUB_JOY_X: begin
              r_code = item.cmd_code;
              {r_high, r_low} = st.joy[0];
            end
            pscr_pkg::SUB_JOY_Y: begin
              r_code = item.cmd_code;
              {r_high, r_low} = st.joy[1];
            end
            pscr_pkg::SUB_REVISION: begin
              r_code = item.cmd_code;
              r_low  = cfg.revision_code;
            end
            pscr_pkg::SUB_CHECKSUM: begin
              r_code = item.cmd_code;
              r_low  = cfg.checksum_low;
              r_high = cfg.checksum_high;
            end
            pscr_pkg::SUB_NEEDLE: begin
              r_code = item.cmd_code;
              {r_high, r_low} = item.needle_value;
            end
            pscr_pkg::SUB_PEEK: begin
              r_code = item.cmd_code;
              r_low  = st.status_low;
              r_high = st.status_high;
            end
            default: begin
            end
          endcase
        end
        pscr_pkg::CMD_POS_X, pscr_pkg::CMD_POS_Y, pscr_pkg::CMD_POS_Z: begin
          if (item.cmd_sub == pscr_pkg::SUB_AXIS_POS) begin
            r_code = item.cmd_code;
            case (item.cmd_code)
              pscr_pkg::CMD_POS_X: {r_high, r_low} = st.pos[0];
              pscr_pkg::CMD_POS_Y: {r_high, r_low} = st.pos[1];
              default:             {r_high, r_low} = st.pos[2];
            endcase
          end else if (item.cmd_sub == pscr_pkg::SUB_AXIS_TGT) begin
            r_code = item.cmd_code;
            case (item.cmd_code)
              pscr_pkg::CMD_POS_X: {r_high, r_low} = st.tgt[0];
              pscr_pkg::CMD_POS_Y: {r_high, r_low} = st.tgt[1];
              default:             {r_high, r_low} = st.tgt[2];
            endcase
          end
        end
        pscr_pkg::CMD_TGT_X, pscr_pkg::CMD_TGT_Y, pscr_pkg::CMD_TGT_Z: begin
          r_code = item.cmd_code;
          r_low  = item.cmd_sub;
          r_high = item.cmd_arg;
          case (item.cmd_code)
            pscr_pkg::CMD_TGT_X: s.tgt[0] = {item.cmd_arg, item.cmd_sub};
            pscr_pkg::CMD_TGT_Y: s.tgt[1] = {item.cmd_arg, item.cmd_sub};
            default:             s.tgt[2] = {item.cmd_arg, item.cmd_sub};
          endcase
        end
        pscr_pkg::CMD_MOVE: begin
          if (item.cmd_sub == pscr_pkg::SUB_MOVE_XYZ ||
              item.cmd_sub == pscr_pkg::SUB_MOVE_HOME ||
              item.cmd_sub == pscr_pkg::SUB_MOVE_STEP) begin
            s.status_low = pscr_pkg::STAT_MOVING;
            s.pending    = 1'b1;
            case (item.cmd_sub)
              pscr_pkg::SUB_MOVE_HOME: s.kind = pscr_pkg::KIND_HOME;
              pscr_pkg::SUB_MOVE_STEP: s.kind = pscr_pkg::KIND_STEP;
              default:                 s.kind = pscr_pkg::KIND_XYZ;
            endcase
            r_code = pscr_pkg::CMD_MOVE;
            r_low  = pscr_pkg::STAT_MOVING;
            r_high = st.status_high;
          end
        end
        default: begin
        end
      endcase
    end

    st_nxt    = s;
    rep.code  = r_code;
    rep.low   = r_low;
    rep.high  = r_high;
    rep.check = r_code ^ r_low ^ r_high;
  end

endmodule
`default_nettype wire

[src/positioner_serial_command_responder_core.sv]
// Top level of the positioner serial command responder.
// Each request on the input channel is either a 3-byte command frame
// (in_op low) or a controller tick (in_op high), together with the
// sampled link, button, joystick and needle levels.
// A frame yields exactly one 4-byte reply on the output channel; a tick
// yields none and only updates the internal state.
// A request is held in an input register and processed from there: the
// state is updated and, for a frame, the reply is loaded into the output
// register, which offers it to the receiver.
// One request can be taken every cycle while the receiver keeps up.
// When the receiver stalls, a waiting reply holds the output register and
// a frame behind it waits in the input register, holding back every
// request after it; a tick in the input register never waits for the
// receiver.
// Configuration writes on the cfg_ port take effect at once; they are to be
// made only while the block is idle, which the block itself does not enforce.
// Synchronous reset empties both registers, loads the register defaults
// and arms a full positioner reset on the first connected tick.
`default_nettype none
module positioner_serial_command_responder_core (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        in_op,
  input  wire [7:0]  in_cmd_code,
  input  wire [7:0]  in_cmd_sub,
  input  wire [7:0]  in_cmd_arg,
  input  wire        in_link_up,
  input  wire        in_unlock_pressed,
  input  wire [15:0] in_joystick_x,
  input  wire [15:0] in_joystick_y,
  input  wire [15:0] in_needle_value,
  input  wire        in_buttons_write,
  input  wire [4:0]  in_console_buttons,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] out_reply_code,
  output logic [7:0] out_reply_low,
  output logic [7:0] out_reply_high,
  output logic [7:0] out_reply_check,
  input  wire        cfg_we,
  input  wire [2:0]  cfg_index,
  input  wire [15:0] cfg_wdata
);

  pscr_pkg::state_t st_r;
  pscr_pkg::state_t st_nxt;
  pscr_pkg::cfg_t   cfg_r;
  pscr_pkg::item_t  item_r;
  pscr_pkg::reply_t rep_nxt;
  pscr_pkg::reply_t rep_r;
  logic             item_vld_r;
  logic             out_vld_r;
  logic             advance;
  logic             out_free;

  assign out_free = !out_vld_r || out_ready;
  assign advance  = item_vld_r && (item_r.op || out_free);
  assign in_ready = !item_vld_r || advance;

  pscr_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .rep    (rep_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.op              <= in_op;
      item_r.cmd_code        <= in_cmd_code;
      item_r.cmd_sub         <= in_cmd_sub;
      item_r.cmd_arg         <= in_cmd_arg;
      item_r.link_up         <= in_link_up;
      item_r.unlock_pressed  <= in_unlock_pressed;
      item_r.joystick_x      <= in_joystick_x;
      item_r.joystick_y      <= in_joystick_y;
      item_r.needle_value    <= in_needle_value;
      item_r.buttons_write   <= in_buttons_write;
      item_r.console_buttons <= in_console_buttons;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pscr_pkg::STATE_RESET;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && !item_r.op) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !item_r.op) begin
      rep_r <= rep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.revision_code     <= 8'd1;
      cfg_r.checksum_low      <= 8'hAA;
      cfg_r.checksum_high     <= 8'hBB;
      cfg_r.button_hold_ticks <= 4'd10;
      cfg_r.z_step            <= 8'd10;
      cfg_r.z_limit           <= 16'd1300;
    end else if (cfg_we) begin
      case (cfg_index)
        pscr_pkg::REG_REVISION: cfg_r.revision_code     <= cfg_wdata[7:0];
        pscr_pkg::REG_CKSUM_LO: cfg_r.checksum_low      <= cfg_wdata[7:0];
        pscr_pkg::REG_CKSUM_HI: cfg_r.checksum_high     <= cfg_wdata[7:0];
        pscr_pkg::REG_HOLD:     cfg_r.button_hold_ticks <= cfg_wdata[3:0];
        pscr_pkg::REG_Z_STEP:   cfg_r.z_step            <= cfg_wdata[7:0];
        pscr_pkg::REG_Z_LIMIT:  cfg_r.z_limit           <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_valid       = out_vld_r;
  assign out_reply_code  = rep_r.code;
  assign out_reply_low   = rep_r.low;
  assign out_reply_high  = rep_r.high;
  assign out_reply_check = rep_r.check;

endmodule
`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the positioner serial command responder core.
module testbench;
  import pscr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REQUESTS_PER_PHASE = 267;
  localparam int PHASE_COUNT = 6;
  localparam int SEQ_BIT = 3;
  localparam int UNLOCK_BIT = 6;
  localparam reply_t ZERO_REPLY = '0;

  typedef struct {
    item_t  req;
    bit     typed;
    reply_t want;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_op = 1'b0;
  logic [7:0]  in_cmd_code = '0;
  logic [7:0]  in_cmd_sub = '0;
  logic [7:0]  in_cmd_arg = '0;
  logic        in_link_up = 1'b0;
  logic        in_unlock_pressed = 1'b0;
  logic [15:0] in_joystick_x = '0;
  logic [15:0] in_joystick_y = '0;
  logic [15:0] in_needle_value = '0;
  logic        in_buttons_write = 1'b0;
  logic [4:0]  in_console_buttons = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_reply_code;
  logic [7:0]  out_reply_low;
  logic [7:0]  out_reply_high;
  logic [7:0]  out_reply_check;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  positioner_serial_command_responder_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_cmd_code(in_cmd_code),
    .in_cmd_sub(in_cmd_sub),
    .in_cmd_arg(in_cmd_arg),
    .in_link_up(in_link_up),
    .in_unlock_pressed(in_unlock_pressed),
    .in_joystick_x(in_joystick_x),
    .in_joystick_y(in_joystick_y),
    .in_needle_value(in_needle_value),
    .in_buttons_write(in_buttons_write),
    .in_console_buttons(in_console_buttons),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_reply_code(out_reply_code),
    .out_reply_low(out_reply_low),
    .out_reply_high(out_reply_high),
    .out_reply_check(out_reply_check),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  cfg_t        cur_cfg;
  logic [7:0]  stat_lo;
  logic [7:0]  stat_hi;
  logic [15:0] axis_pos [3];
  logic [15:0] axis_tgt [3];
  logic [15:0] joy_sample [2];
  logic [4:0]  btn_latch;
  logic [3:0]  hold_count;
  bit          move_pending;
  logic [1:0]  move_kind;
  bit          reset_armed;

  reply_t      expected_replies [$];
  step_row_t   directed_rows [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;

  function automatic reply_t pack_reply(logic [7:0] code, logic [7:0] lo, logic [7:0] hi);
    return {code, lo, hi, code ^ lo ^ hi};
  endfunction

  task automatic predict_positioner(input item_t rq, output bit produces, output reply_t r);
    logic [15:0] word;
    logic [16:0] z_sum;
    int unsigned axis;
    word = {rq.cmd_arg, rq.cmd_sub};
    produces = 1'b0;
    r = ZERO_REPLY;
    if (rq.buttons_write) begin
      btn_latch = rq.console_buttons;
      hold_count = cur_cfg.button_hold_ticks;
    end
    if (rq.op) begin
      if (!rq.link_up) begin
        reset_armed = 1'b1;
        return;
      end
      if (reset_armed) begin
        stat_lo = STAT_READY;
        stat_hi = STAT_HIGH_INIT;
        axis_pos = '{default: '0};
        btn_latch = '0;
        hold_count = '0;
        move_pending = 1'b0;
        reset_armed = 1'b0;
      end
      if (hold_count == 0) begin
        btn_latch = '0;
      end else begin
        hold_count = hold_count - 4'd1;
      end
      stat_hi = (stat_hi & KEEP_MASK_HIGH) | {3'b000, btn_latch};
      if (stat_hi[SEQ_BIT]) begin
        joy_sample[0] = rq.joystick_x;
        joy_sample[1] = rq.joystick_y;
      end
      if (rq.unlock_pressed) begin
        stat_hi[UNLOCK_BIT] = 1'b1;
      end
      if (move_pending) begin
        if (move_kind == KIND_HOME) begin
          axis_tgt = '{default: '0};
        end else if (move_kind == KIND_STEP) begin
          if (axis_tgt[2] > cur_cfg.z_limit) begin
            axis_tgt[2] = cur_cfg.z_limit;
          end else begin
            z_sum = {1'b0, axis_tgt[2]} + cur_cfg.z_step;
            axis_tgt[2] = z_sum[16] ? 16'hFFFF : z_sum[15:0];
          end
        end
        axis_pos = axis_tgt;
        stat_lo = (axis_pos[0] == 0 && axis_pos[1] == 0 && axis_pos[2] == 0) ?
                  STAT_HOME : STAT_READY;
        move_pending = 1'b0;
      end
      return;
    end
    produces = 1'b1;
    if (move_pending || !rq.link_up) begin
      return;
    end
    case (rq.cmd_code)
      CMD_STATUS: begin
        case (rq.cmd_sub)
          SUB_STATUS: begin
            r = pack_reply(rq.cmd_code, stat_lo, stat_hi);
            if (rq.cmd_arg == ARG_CLEAR) begin
              stat_lo &= CLR_MASK_LOW;
              stat_hi &= CLR_MASK_HIGH;
            end
          end
          SUB_JOY_X: r = pack_reply(rq.cmd_code, joy_sample[0][7:0], joy_sample[0][15:8]);
          SUB_JOY_Y: r = pack_reply(rq.cmd_code, joy_sample[1][7:0], joy_sample[1][15:8]);
          SUB_REVISION: r = pack_reply(rq.cmd_code, cur_cfg.revision_code, 8'h00);
          SUB_CHECKSUM: r = pack_reply(rq.cmd_code, cur_cfg.checksum_low, cur_cfg.checksum_high);
          SUB_NEEDLE: r = pack_reply(rq.cmd_code, rq.needle_value[7:0], rq.needle_value[15:8]);
          SUB_PEEK: r = pack_reply(rq.cmd_code, stat_lo, stat_hi);
          default: ;
        endcase
      end
      CMD_POS_X, CMD_POS_Y, CMD_POS_Z: begin
        axis = rq.cmd_code - CMD_POS_X;
        if (rq.cmd_sub == SUB_AXIS_POS) begin
          r = pack_reply(rq.cmd_code, axis_pos[axis][7:0], axis_pos[axis][15:8]);
        end else if (rq.cmd_sub == SUB_AXIS_TGT) begin
          r = pack_reply(rq.cmd_code, axis_tgt[axis][7:0], axis_tgt[axis][15:8]);
        end
      end
      CMD_TGT_X, CMD_TGT_Y, CMD_TGT_Z: begin
        axis = rq.cmd_code - CMD_TGT_X;
        axis_tgt[axis] = word;
        r = pack_reply(rq.cmd_code, word[7:0], word[15:8]);
      end
      CMD_MOVE: begin
        if (rq.cmd_sub == SUB_MOVE_XYZ || rq.cmd_sub == SUB_MOVE_HOME ||
            rq.cmd_sub == SUB_MOVE_STEP) begin
          stat_lo = STAT_MOVING;
          move_pending = 1'b1;
          move_kind = (rq.cmd_sub == SUB_MOVE_HOME) ? KIND_HOME :
                      (rq.cmd_sub == SUB_MOVE_STEP) ? KIND_STEP : KIND_XYZ;
          r = pack_reply(CMD_MOVE, stat_lo, stat_hi);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input item_t rq, input bit typed, input reply_t want);
    bit     produces;
    reply_t r;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_op <= rq.op;
    in_cmd_code <= rq.cmd_code;
    in_cmd_sub <= rq.cmd_sub;
    in_cmd_arg <= rq.cmd_arg;
    in_link_up <= rq.link_up;
    in_unlock_pressed <= rq.unlock_pressed;
    in_joystick_x <= rq.joystick_x;
    in_joystick_y <= rq.joystick_y;
    in_needle_value <= rq.needle_value;
    in_buttons_write <= rq.buttons_write;
    in_console_buttons <= rq.console_buttons;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_positioner(rq, produces, r);
    if (produces) begin
      expected_replies.push_back(typed ? want : r);
    end
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_settings(input cfg_t c);
    logic [2:0]  index [6] = '{REG_REVISION, REG_CKSUM_LO, REG_CKSUM_HI,
                               REG_HOLD, REG_Z_STEP, REG_Z_LIMIT};
    logic [15:0] value [6];
    value = '{16'(c.revision_code), 16'(c.checksum_low), 16'(c.checksum_high),
              16'(c.button_hold_ticks), 16'(c.z_step), c.z_limit};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= index[i];
      cfg_wdata <= value[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic step_row_t make_row(bit op, logic [7:0] code, logic [7:0] sub,
                                         logic [7:0] arg, bit link, bit unlock, bit bwrite,
                                         logic [4:0] buttons, logic [15:0] level,
                                         bit typed, reply_t want);
    step_row_t row;
    row.req = '{op: op, cmd_code: code, cmd_sub: sub, cmd_arg: arg, link_up: link,
                unlock_pressed: unlock, joystick_x: level, joystick_y: ~level,
                needle_value: level, buttons_write: bwrite, console_buttons: buttons};
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic item_t random_request();
    item_t       rq;
    int unsigned pick;
    logic [7:0]  axis;
    rq.op = ($urandom_range(99) < 30);
    rq.cmd_code = CMD_STATUS;
    rq.cmd_sub = SUB_PEEK;
    rq.cmd_arg = 8'($urandom());
    rq.link_up = ($urandom_range(99) < 94);
    rq.unlock_pressed = 1'($urandom_range(1));
    rq.joystick_x = 16'($urandom());
    rq.joystick_y = 16'($urandom());
    rq.needle_value = 16'($urandom());
    rq.buttons_write = ($urandom_range(99) < 20);
    rq.console_buttons = 5'($urandom());
    pick = $urandom_range(19);
    axis = 8'($urandom_range(2));
    case (pick)
      0, 1: begin
        rq.cmd_sub = SUB_STATUS;
        rq.cmd_arg = $urandom_range(1) ? ARG_CLEAR : 8'($urandom());
      end
      2: rq.cmd_sub = SUB_JOY_X;
      3: rq.cmd_sub = SUB_JOY_Y;
      4: rq.cmd_sub = SUB_REVISION;
      5: rq.cmd_sub = SUB_CHECKSUM;
      6: rq.cmd_sub = SUB_NEEDLE;
      7: rq.cmd_sub = SUB_PEEK;
      8, 9: begin
        rq.cmd_code = CMD_POS_X + axis;
        rq.cmd_sub = $urandom_range(1) ? SUB_AXIS_TGT : SUB_AXIS_POS;
      end
      10, 11, 12: begin
        rq.cmd_code = CMD_TGT_X + axis;
        rq.cmd_sub = 8'($urandom());
        rq.cmd_arg = ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(6));
      end
      13, 14, 15: begin
        rq.cmd_code = CMD_MOVE;
        case ($urandom_range(2))
          0: rq.cmd_sub = SUB_MOVE_XYZ;
          1: rq.cmd_sub = SUB_MOVE_STEP;
          default: rq.cmd_sub = SUB_MOVE_HOME;
        endcase
      end
      16: begin
        rq.cmd_code = CMD_MOVE;
        rq.cmd_sub = 8'($urandom());
      end
      17: begin
        rq.cmd_code = CMD_POS_X + axis;
        rq.cmd_sub = 8'($urandom());
      end
      default: begin
        rq.cmd_code = 8'($urandom());
        rq.cmd_sub = 8'($urandom_range(7));
      end
    endcase
    return rq;
  endfunction

  always @(negedge clk) begin
    out_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    reply_t seen;
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      seen = {out_reply_code, out_reply_low, out_reply_high, out_reply_check};
      if (expected_replies.size() == 0) begin
        $error("reply %h arrived with no request waiting for it", seen);
        mismatch_count++;
      end else begin
        want = expected_replies.pop_front();
        if (seen.code !== want.code) begin
          $error("reply_code: expected %h, got %h", want.code, seen.code);
          mismatch_count++;
        end
        if (seen.low !== want.low) begin
          $error("reply_low: expected %h, got %h", want.low, seen.low);
          mismatch_count++;
        end
        if (seen.high !== want.high) begin
          $error("reply_high: expected %h, got %h", want.high, seen.high);
          mismatch_count++;
        end
        if (seen.check !== want.check) begin
          $error("reply_check: expected %h, got %h", want.check, seen.check);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    cfg_t phase_cfg;
    cur_cfg = {8'd1, 8'hAA, 8'hBB, 4'd10, 8'd10, 16'd1300};
    stat_lo = '0;
    stat_hi = '0;
    axis_pos = '{default: '0};
    axis_tgt = '{default: '0};
    joy_sample = '{default: '0};
    btn_latch = '0;
    hold_count = '0;
    move_pending = 1'b0;
    move_kind = KIND_XYZ;
    reset_armed = 1'b1;

    // A frame before the first connected tick, then the reconnect reset.
    directed_rows.push_back(make_row(0, CMD_STATUS, SUB_PEEK, 0, 0, 0, 0, 0, 0, 1, ZERO_REPLY));
    directed_rows.push_back(make_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, ZERO_REPLY));
    directed_rows.push_back(make_row(1, 0, 0, 0, 1, 1, 0, 0, 16'hFFFF, 0, ZERO_REPLY));
    directed_rows.push_back(make_row(0, CMD_STATUS, SUB_PEEK, 0, 1, 0, 0, 0, 0, 1,
                                     reply_t'({8'h8D, 8'h42, 8'hC0, 8'h0F})));
    directed_rows.push_back(make_row(0, CMD_STATUS, SUB_REVISION, 0, 1, 0, 0, 0, 0, 1,
                                     reply_t'({8'h8D, 8'h01, 8'h00, 8'h8C})));
    directed_rows.push_back(make_row(0, CMD_STATUS, SUB_CHECKSUM, 0, 1, 0, 0, 0, 0, 1,
                                     reply_t'({8'h8D, 8'hAA, 8'hBB, 8'h9C})));
    directed_rows.push_back(make_row(0, CMD_STATUS, SUB_NEEDLE, 0, 1, 0, 0, 0, 16'hFFFF, 1,
                                     reply_t'({8'h8D, 8'hFF, 8'hFF, 8'h8D})));
    directed_rows.push_back(make_row(0, CMD_TGT_X, 8'hFF, 8'hFF, 1, 0, 0, 0, 0, 1,
                                     reply_t'({8'hCE, 8'hFF, 8'hFF, 8'hCE})));
    directed_rows.push_back(make_row(0, CMD_TGT_Y, 8'h00, 8'h00, 1, 0, 0, 0, 0, 1,
                                     reply_t'({8'hCF, 8'h00, 8'h00, 8'hCF})));
    directed_rows.push_back(make_row(0, CMD_TGT_Z, 8'h14, 8'h05, 1, 0, 0, 0, 0, 0, ZERO_REPLY));
    directed_rows.push_back(make_row(0, CMD_POS_X, SUB_AXIS_TGT, 0, 1, 0, 0, 0, 0, 0,
                                     ZERO_REPLY));
    // Unknown codes and subcodes.
    directed_rows.push_back(make_row(0, 8'h00, 8'h00, 0, 1, 0, 0, 0, 0, 1, ZERO_REPLY));
    directed_rows.push_back(make_row(0, CMD_STATUS, 8'h07, 0, 1, 0, 0, 0, 0, 1, ZERO_REPLY));
    directed_rows.push_back(make_row(0, CMD_POS_Y, 8'h02, 0, 1, 0, 0, 0, 0, 1, ZERO_REPLY));
    directed_rows.push_back(make_row(0, CMD_MOVE, 8'h01, 0, 1, 0, 0, 0, 0, 1, ZERO_REPLY));
    // A Z step move, a frame while it is pending, then the completing tick.
    directed_rows.push_back(make_row(0, CMD_MOVE, SUB_MOVE_STEP, 0, 1, 0, 0, 0, 0, 0,
                                     ZERO_REPLY));
    directed_rows.push_back(make_row(0, CMD_STATUS, SUB_PEEK, 0, 1, 0, 0, 0, 0, 1, ZERO_REPLY));
    directed_rows.push_back(make_row(1, 0, 0, 0, 1, 0, 1, 5'h1F, 16'h1234, 0, ZERO_REPLY));
    directed_rows.push_back(make_row(0, CMD_POS_Z, SUB_AXIS_POS, 0, 1, 0, 0, 0, 0, 0,
                                     ZERO_REPLY));
    directed_rows.push_back(make_row(0, CMD_STATUS, SUB_JOY_X, 0, 1, 0, 0, 0, 0, 0, ZERO_REPLY));
    directed_rows.push_back(make_row(0, CMD_STATUS, SUB_STATUS, ARG_CLEAR, 1, 0, 0, 0, 0, 0,
                                     ZERO_REPLY));
    directed_rows.push_back(make_row(0, CMD_MOVE, SUB_MOVE_HOME, 0, 1, 0, 0, 0, 0, 0,
                                     ZERO_REPLY));
    directed_rows.push_back(make_row(1, 0, 0, 0, 1, 1, 0, 0, 0, 0, ZERO_REPLY));
    directed_rows.push_back(make_row(0, CMD_POS_X, SUB_AXIS_POS, 0, 1, 0, 0, 0, 0, 0,
                                     ZERO_REPLY));
    // A disconnect while a move is pending; the reconnect reset drops the move.
    directed_rows.push_back(make_row(0, CMD_MOVE, SUB_MOVE_XYZ, 0, 1, 0, 0, 0, 0, 0,
                                     ZERO_REPLY));
    directed_rows.push_back(make_row(1, 0, 0, 0, 0, 0, 1, 5'h08, 0, 0, ZERO_REPLY));
    directed_rows.push_back(make_row(1, 0, 0, 0, 1, 0, 0, 0, 16'h00FF, 0, ZERO_REPLY));
    directed_rows.push_back(make_row(0, CMD_STATUS, SUB_PEEK, 0, 1, 0, 0, 0, 0, 0, ZERO_REPLY));

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 26;
    rx_idle_pct = 87;
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      settle();
      case (phase)
        0: phase_cfg = '0;
        1: phase_cfg = '1;
        default: phase_cfg = cfg_t'({$urandom(), $urandom()});
      endcase
      load_settings(phase_cfg);
      if (phase < 2) begin
        tx_idle_pct = 26;
        rx_idle_pct = 87;
      end else if (phase < 4) begin
        tx_idle_pct = 87;
        rx_idle_pct = 26;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      repeat (REQUESTS_PER_PHASE) send_request(random_request(), 1'b0, ZERO_REPLY);
    end
    settle();

    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
